// ===== hdl/pdvm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase derivative variance map: shared package
// Types, register codes and default sizes used by every module of the block.
// ----------------------------------------------------------------------------
package pdvm_pkg;

   // Default sizes handed to the top level parameters.
   localparam int unsigned MAX_WIDTH_DEF  = 1024;
   localparam int unsigned PHASE_BITS_DEF = 16;

   // Fixed field widths.
   localparam int unsigned QUALITY_BITS = 16;
   localparam int unsigned WIDTH_BITS   = 11;
   localparam int unsigned HEIGHT_BITS  = 12;
   localparam int unsigned PADDR_BITS   = 3;
   localparam int unsigned PDATA_BITS   = 32;

   // Register file: byte address 4*index, index taken from address bit 2.
   localparam int unsigned REG_SEL_BIT = 2;
   localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 12'd480;

   // Control sideband that travels with each pixel down the pipeline.
   typedef struct packed {
      logic valid;       // stage holds a pixel
      logic has_first;   // pixel releases the result of the row above
      logic first_last;  // that result closes the pixel's results
      logic has_second;  // pixel is in the last row and adds its own zero
      logic eof;         // the second result ends the frame
   } pdvm_ctl_type;

endpackage

// ===== hdl/pdvm_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase derivative variance map: raster window
// Column and row counters, the two line stores and the first pipeline stage
// that presents the center pixel of the row above with its four neighbors.
// ----------------------------------------------------------------------------
module pdvm_window #(
   parameter int unsigned MAX_WIDTH  = pdvm_pkg::MAX_WIDTH_DEF,
   parameter int unsigned PHASE_BITS = pdvm_pkg::PHASE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                restart,
   input  logic                                req_valid,
   input  logic [PHASE_BITS-1:0]               req_phase,
   input  logic [pdvm_pkg::WIDTH_BITS-1:0]     image_width,
   input  logic [pdvm_pkg::HEIGHT_BITS-1:0]    image_height,
   output pdvm_pkg::pdvm_ctl_type              win_ctl,
   output logic [PHASE_BITS-1:0]               win_center,
   output logic [3:0][PHASE_BITS-1:0]          win_nb
);
   import pdvm_pkg::*;

   localparam int unsigned ADDR_BITS = $clog2(MAX_WIDTH);
   localparam int unsigned WB        = $clog2(MAX_WIDTH + 1);

   // Line stores: entry c holds row r-2 (upper) and row r-1 (middle).
   logic [PHASE_BITS-1:0] upper_row_ff  [MAX_WIDTH];
   logic [PHASE_BITS-1:0] middle_row_ff [MAX_WIDTH];

   logic [ADDR_BITS-1:0]   col_ff, col_in, col_nxt;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [WB-1:0]          w_eff;
   logic [HEIGHT_BITS-1:0] h_eff;
   logic                   last_col, last_row, interior, accept, wr_en;

   pdvm_ctl_type          s1_ctl_ff, s1_ctl_in;
   logic [PHASE_BITS-1:0] s1_phase_ff;
   logic [ADDR_BITS-1:0]  s1_col_ff;
   logic                  s1_interior_ff;
   logic [PHASE_BITS-1:0] up_rd_ff, mid_rd_ff, nxt_rd_ff, prev_mid_ff;

   // Clamp the frame size registers to usable values.
   always_comb begin
      if (32'(image_width) > 32'(MAX_WIDTH)) begin
         w_eff = WB'(MAX_WIDTH);
      end else if (image_width < 11'd3) begin
         w_eff = WB'(3);
      end else begin
         w_eff = WB'(image_width);
      end
      if (image_height < 12'd3) begin
         h_eff = 12'd3;
      end else begin
         h_eff = image_height;
      end
   end

   assign accept   = req_valid && adv;
   assign last_col = (WB'(col_ff) + WB'(1)) >= w_eff;
   assign last_row = ((HEIGHT_BITS + 1)'(row_ff) + (HEIGHT_BITS + 1)'(1))
                     >= (HEIGHT_BITS + 1)'(h_eff);
   assign interior = (row_ff >= HEIGHT_BITS'(2)) && (col_ff != '0) && !last_col;
   assign col_nxt  = col_ff + ADDR_BITS'(1);

   // Raster position for the next pixel.
   always_comb begin
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + HEIGHT_BITS'(1);
      end else begin
         col_in = col_nxt;
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Sideband for the accepted pixel.
   always_comb begin
      s1_ctl_in            = '0;
      s1_ctl_in.valid      = accept;
      s1_ctl_in.has_first  = accept && (row_ff != '0);
      s1_ctl_in.first_last = accept && !last_row;
      s1_ctl_in.has_second = accept && last_row;
      s1_ctl_in.eof        = accept && last_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (adv) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   // Stage one payload and the registered store reads at the transfer edge.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_phase_ff    <= req_phase;
         s1_col_ff      <= col_ff;
         s1_interior_ff <= interior;
         up_rd_ff       <= upper_row_ff[col_ff];
         mid_rd_ff      <= middle_row_ff[col_ff];
         nxt_rd_ff      <= middle_row_ff[col_nxt];
      end
   end

   // The pixel leaving stage one shifts its column down one row.
   assign wr_en = adv && s1_ctl_ff.valid;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_row_ff[s1_col_ff]  <= mid_rd_ff;
         middle_row_ff[s1_col_ff] <= s1_phase_ff;
      end
   end

   // Left neighbor of the center is the middle value of the previous column.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         prev_mid_ff <= mid_rd_ff;
      end
   end

   // Border pixels see an all-zero window, which yields a zero quality.
   assign win_ctl    = s1_ctl_ff;
   assign win_center = s1_interior_ff ? mid_rd_ff   : '0;
   assign win_nb[0]  = s1_interior_ff ? up_rd_ff    : '0;
   assign win_nb[1]  = s1_interior_ff ? prev_mid_ff : '0;
   assign win_nb[2]  = s1_interior_ff ? nxt_rd_ff   : '0;
   assign win_nb[3]  = s1_interior_ff ? s1_phase_ff : '0;

endmodule

// ===== hdl/pdvm_spread.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase derivative variance map: gradient spread
// Wraps the four neighbor differences, forms their deviations from the mean,
// squares them and sums them into the radicand of the square root chain.
// ----------------------------------------------------------------------------
module pdvm_spread #(
   parameter int unsigned PHASE_BITS = pdvm_pkg::PHASE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  pdvm_pkg::pdvm_ctl_type        in_ctl,
   input  logic [PHASE_BITS-1:0]         in_center,
   input  logic [3:0][PHASE_BITS-1:0]    in_nb,
   output pdvm_pkg::pdvm_ctl_type        out_ctl,
   output logic [2*PHASE_BITS-1:0]       out_rad
);
   import pdvm_pkg::*;

   localparam int unsigned DW = PHASE_BITS + 1;      // wrapped difference
   localparam int unsigned EW = PHASE_BITS + 4;      // deviation, with headroom
   localparam int unsigned MW = PHASE_BITS + 2;      // deviation magnitude
   localparam int unsigned SW = 2 * PHASE_BITS + 4;  // one square
   localparam int unsigned AW = 2 * PHASE_BITS + 6;  // sum of four squares
   localparam logic signed [PHASE_BITS+1:0] HALF_CYCLE =
      $signed((PHASE_BITS + 2)'(1) << (PHASE_BITS - 1));
   localparam logic signed [PHASE_BITS+1:0] FULL_CYCLE =
      $signed((PHASE_BITS + 2)'(1) << PHASE_BITS);

   pdvm_ctl_type c2_ff, c3_ff, c4_ff, c5_ff;

   logic signed [DW-1:0]     d_in   [4];
   logic signed [DW-1:0]     d_ff   [4];
   logic [MW-1:0]            mag_in [4];
   logic [MW-1:0]            mag_ff [4];
   logic [SW-1:0]            sq_in  [4];
   logic [SW-1:0]            sq_ff  [4];
   logic [2*PHASE_BITS-1:0]  rad_in, rad_ff;

   // Center minus neighbor, wrapped into half a cycle either way.
   always_comb begin
      logic signed [PHASE_BITS+1:0] raw;
      for (int k = 0; k < 4; k++) begin
         raw = $signed({2'b00, in_center}) - $signed({2'b00, in_nb[k]});
         if (raw > HALF_CYCLE) begin
            raw = raw - FULL_CYCLE;
         end else if (raw < -HALF_CYCLE) begin
            raw = raw + FULL_CYCLE;
         end
         d_in[k] = $signed(raw[DW-1:0]);
      end
   end

   // Deviation of each difference from the mean, scaled by four.
   always_comb begin
      logic signed [EW-1:0] sum_c;
      logic signed [EW-1:0] dev;
      sum_c = '0;
      for (int k = 0; k < 4; k++) begin
         sum_c = sum_c + EW'(d_ff[k]);
      end
      for (int k = 0; k < 4; k++) begin
         dev = (EW'(d_ff[k]) <<< 2) - sum_c;
         mag_in[k] = (dev < 0) ? MW'(-dev) : MW'(dev);
      end
   end

   // Squares of the deviation magnitudes.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sq_in[k] = SW'(mag_ff[k]) * SW'(mag_ff[k]);
      end
   end

   // Sum of squares over 64 gives the variance.
   always_comb begin
      logic [AW-1:0] acc;
      acc = '0;
      for (int k = 0; k < 4; k++) begin
         acc = acc + AW'(sq_ff[k]);
      end
      rad_in = acc[AW-1:6];
   end

   // Sideband follows the payload one stage at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
      end else if (adv) begin
         c2_ff <= in_ctl;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
         c5_ff <= c4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff   <= d_in;
         mag_ff <= mag_in;
         sq_ff  <= sq_in;
         rad_ff <= rad_in;
      end
   end

   assign out_ctl = c5_ff;
   assign out_rad = rad_ff;

endmodule

// ===== hdl/pdvm_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase derivative variance map: square root cell
// One cell of the root chain. It settles one root bit from the next two
// radicand bits and hands the partial root and remainder to its neighbor.
// ----------------------------------------------------------------------------
module pdvm_sqrt_cell #(
   parameter int unsigned PHASE_BITS = pdvm_pkg::PHASE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  pdvm_pkg::pdvm_ctl_type     in_ctl,
   input  logic [2*PHASE_BITS-1:0]    in_rad,
   input  logic [PHASE_BITS+1:0]      in_rem,
   input  logic [PHASE_BITS-1:0]      in_root,
   output pdvm_pkg::pdvm_ctl_type     out_ctl,
   output logic [2*PHASE_BITS-1:0]    out_rad,
   output logic [PHASE_BITS+1:0]      out_rem,
   output logic [PHASE_BITS-1:0]      out_root
);
   import pdvm_pkg::*;

   localparam int unsigned RW = PHASE_BITS + 4;

   pdvm_ctl_type            ctl_ff;
   logic [2*PHASE_BITS-1:0] rad_ff, rad_in;
   logic [PHASE_BITS+1:0]   rem_ff, rem_in;
   logic [PHASE_BITS-1:0]   root_ff, root_in;
   logic [RW-1:0]           wide, trial;

   // Bring down two radicand bits and try 4*root+1 against the remainder.
   assign wide   = {in_rem, in_rad[2*PHASE_BITS-1 -: 2]};
   assign trial  = RW'({in_root, 2'b01});
   assign rad_in = in_rad << 2;

   always_comb begin
      if (wide >= trial) begin
         rem_in  = (PHASE_BITS + 2)'(wide - trial);
         root_in = {in_root[PHASE_BITS-2:0], 1'b1};
      end else begin
         rem_in  = (PHASE_BITS + 2)'(wide);
         root_in = {in_root[PHASE_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_rad  = rad_ff;
   assign out_rem  = rem_ff;
   assign out_root = root_ff;

endmodule

// ===== hdl/phase_derivative_variance_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase derivative variance map: top level
// Streams wrapped phase pixels in raster order and returns, for each pixel of
// the row above, the standard deviation of its four wrapped gradients.
// ----------------------------------------------------------------------------
//  Channel   Direction   Handshake              Payload
//  req       in          req_valid/req_stall    req_phase
//  rsp       out         rsp_valid/rsp_stall    rsp_quality, rsp_last_in_run,
//                                               rsp_end_of_frame
//  csr       in          psel/penable/pready    image_width at 0x0,
//                                               image_height at 0x4
//
//  One pixel is taken per clock while the output is not held. In the last row
//  each pixel gives two results, so there the input waits while the output
//  drains. A first result passes the window stage, the spread stages, the
//  root chain of PHASE_BITS cells (one root bit per cell) and the output register.
//  Reset clears the pipeline, the counters and the registers (640 by 480);
//  the line stores are not cleared. A stalled result freezes the whole
//  pipeline, and req_stall is high for as long as it does.
// ----------------------------------------------------------------------------
module phase_derivative_variance_map #(
   parameter int unsigned MAX_WIDTH  = pdvm_pkg::MAX_WIDTH_DEF,
   parameter int unsigned PHASE_BITS = pdvm_pkg::PHASE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Pixel input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [PHASE_BITS-1:0]             req_phase,
   // Result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pdvm_pkg::QUALITY_BITS-1:0] rsp_quality,
   output logic                              rsp_last_in_run,
   output logic                              rsp_end_of_frame,
   // Register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pdvm_pkg::PADDR_BITS-1:0]   paddr,
   input  logic [pdvm_pkg::PDATA_BITS-1:0]   pwdata,
   output logic [pdvm_pkg::PDATA_BITS-1:0]   prdata,
   output logic                              pready
);
   import pdvm_pkg::*;

   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic                   cfg_write, adv;

   pdvm_ctl_type                 win_ctl, spr_ctl;
   logic [PHASE_BITS-1:0]        win_center;
   logic [3:0][PHASE_BITS-1:0]   win_nb;
   logic [2*PHASE_BITS-1:0]      spr_rad;

   pdvm_ctl_type            chain_ctl  [PHASE_BITS+1];
   logic [2*PHASE_BITS-1:0] chain_rad  [PHASE_BITS+1];
   logic [PHASE_BITS+1:0]   chain_rem  [PHASE_BITS+1];
   logic [PHASE_BITS-1:0]   chain_root [PHASE_BITS+1];

   pdvm_ctl_type            tail_ctl;
   logic [QUALITY_BITS-1:0] tail_quality;

   logic                    out_valid_ff, out_last_ff, out_eof_ff;
   logic [QUALITY_BITS-1:0] out_quality_ff;
   logic                    pend_ff, pend_eof_ff;
   logic                    out_take;

   // Register port: zero wait states, a write restarts the frame.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (cfg_write) begin
         unique case (paddr[REG_SEL_BIT])
            REG_IMAGE_WIDTH:  width_ff  <= pwdata[WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT: height_ff <= pwdata[HEIGHT_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[REG_SEL_BIT])
         REG_IMAGE_WIDTH:  prdata = PDATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT: prdata = PDATA_BITS'(height_ff);
      endcase
   end

   // The pipeline moves when the output register can take its tail.
   assign out_take  = out_valid_ff && !rsp_stall;
   assign adv       = !out_valid_ff || (!rsp_stall && !pend_ff);
   assign req_stall = !adv;

   pdvm_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PHASE_BITS (PHASE_BITS)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .restart      (cfg_write),
      .req_valid    (req_valid),
      .req_phase    (req_phase),
      .image_width  (width_ff),
      .image_height (height_ff),
      .win_ctl      (win_ctl),
      .win_center   (win_center),
      .win_nb       (win_nb)
   );

   pdvm_spread #(
      .PHASE_BITS (PHASE_BITS)
   ) u_spread (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_ctl    (win_ctl),
      .in_center (win_center),
      .in_nb     (win_nb),
      .out_ctl   (spr_ctl),
      .out_rad   (spr_rad)
   );

   // Square root chain, one cell per root bit.
   assign chain_ctl[0]  = spr_ctl;
   assign chain_rad[0]  = spr_rad;
   assign chain_rem[0]  = '0;
   assign chain_root[0] = '0;

   for (genvar i = 0; i < PHASE_BITS; i++) begin : g_root
      pdvm_sqrt_cell #(
         .PHASE_BITS (PHASE_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_ctl   (chain_ctl[i]),
         .in_rad   (chain_rad[i]),
         .in_rem   (chain_rem[i]),
         .in_root  (chain_root[i]),
         .out_ctl  (chain_ctl[i+1]),
         .out_rad  (chain_rad[i+1]),
         .out_rem  (chain_rem[i+1]),
         .out_root (chain_root[i+1])
      );
   end

   assign tail_ctl     = chain_ctl[PHASE_BITS];
   assign tail_quality = QUALITY_BITS'(chain_root[PHASE_BITS]);

   // Output register; a last-row pixel leaves its zero result pending.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else if (out_take && pend_ff) begin
         out_valid_ff <= 1'b1;
         pend_ff      <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= tail_ctl.valid && (tail_ctl.has_first || tail_ctl.has_second);
         pend_ff      <= tail_ctl.valid && tail_ctl.has_first && tail_ctl.has_second;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take && pend_ff) begin
         out_quality_ff <= '0;
         out_last_ff    <= 1'b1;
         out_eof_ff     <= pend_eof_ff;
      end else if (adv) begin
         if (tail_ctl.has_first) begin
            out_quality_ff <= tail_quality;
            out_last_ff    <= tail_ctl.first_last;
            out_eof_ff     <= 1'b0;
         end else begin
            out_quality_ff <= '0;
            out_last_ff    <= 1'b1;
            out_eof_ff     <= tail_ctl.eof;
         end
         pend_eof_ff <= tail_ctl.eof;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_quality      = out_quality_ff;
   assign rsp_last_in_run  = out_last_ff;
   assign rsp_end_of_frame = out_eof_ff;

   // A pending zero result always sits behind a shown first result.
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (out_valid_ff && !out_eof_ff))
      else $error("pending second result without a shown first result");

   // A held result must hold back the input as well.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while a result is stalled");

   // The end of the frame is always the final result of its pixel.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_frame) |-> rsp_last_in_run)
      else $error("end of frame on a result that is not the last of its pixel");

   // After the first of two results is taken, the zero result follows at once.
   assert property (@(posedge clock) disable iff (reset)
      (out_take && pend_ff) |=> (rsp_valid && rsp_last_in_run && (rsp_quality == '0)))
      else $error("last-row zero result not presented after the first result");

endmodule

// ===== bench/tb_phase_derivative_variance_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase derivative variance map: testbench
// Streams phase pixels through the block and checks every result against a
// cycle-free predictor of the quality map kept in this bench. Directed frames
// cover wrap and half-cycle cases, register tests cover reset values, clamping
// and masking at the size extremes, and random frames run under four idling
// patterns on both channels.
// ----------------------------------------------------------------------------
module tb_phase_derivative_variance_map;
   import pdvm_pkg::*;

   localparam int unsigned PHASE_W    = PHASE_BITS_DEF;
   localparam int unsigned LINE_DEPTH = MAX_WIDTH_DEF;
   localparam longint FULL_CYCLE = longint'(1) << PHASE_W;
   localparam longint HALF_CYCLE = FULL_CYCLE / 2;
   // The tail covers the pipeline depth and leaves a margin on top.
   localparam int PIPE_TAIL    = 40;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int RANDOM_ITEMS = 100;
   localparam int TIMEOUT_NS   = 4_000_000;

   typedef struct packed {
      logic [QUALITY_BITS-1:0] quality;
      logic                    last_in_run;
      logic                    end_of_frame;
   } quality_result_type;

   typedef enum int {PIX_UNIFORM, PIX_SMOOTH, PIX_HALF, PIX_FLAT} pixel_kind_type;

   // Clock, reset and block ports.
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [PHASE_W-1:0]      req_phase = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [QUALITY_BITS-1:0] rsp_quality;
   logic                    rsp_last_in_run;
   logic                    rsp_end_of_frame;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [PADDR_BITS-1:0]   paddr = '0;
   logic [PDATA_BITS-1:0]   pwdata = '0;
   logic [PDATA_BITS-1:0]   prdata;
   logic                    pready;

   // Predictor state: line stores, position in the frame and register copies.
   logic [PHASE_W-1:0]     upper_line [LINE_DEPTH];
   logic [PHASE_W-1:0]     middle_line [LINE_DEPTH];
   int unsigned            col_pos = 0;
   int unsigned            row_pos = 0;
   logic [WIDTH_BITS-1:0]  width_reg = WIDTH_RESET;
   logic [HEIGHT_BITS-1:0] height_reg = HEIGHT_RESET;
   quality_result_type     quality_queue [$];

   // Traffic shaping and bookkeeping.
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   logic [PHASE_W-1:0] walk_phase = '0;
   int               error_count = 0;
   int               pixel_count = 0;
   int               result_count = 0;
   int               write_count = 0;

   phase_derivative_variance_map #(
      .MAX_WIDTH  (MAX_WIDTH_DEF),
      .PHASE_BITS (PHASE_W)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_phase        (req_phase),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_quality      (rsp_quality),
      .rsp_last_in_run  (rsp_last_in_run),
      .rsp_end_of_frame (rsp_end_of_frame),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver stalls at random at the rate of the current phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Difference of two phases, wrapped into half a cycle either way.
   function automatic longint wrapped_diff(input logic [PHASE_W-1:0] a,
                                           input logic [PHASE_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d > HALF_CYCLE)
         d -= FULL_CYCLE;
      else if (d < -HALF_CYCLE)
         d += FULL_CYCLE;
      return d;
   endfunction

   // Integer square root, one result bit at a time from the top.
   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 24; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v)
            root = trial;
      end
      return root;
   endfunction

   // Standard deviation of the four wrapped gradients around one pixel.
   function automatic logic [QUALITY_BITS-1:0] gradient_spread(
      input logic [PHASE_W-1:0] center, input logic [PHASE_W-1:0] up,
      input logic [PHASE_W-1:0] left,   input logic [PHASE_W-1:0] right,
      input logic [PHASE_W-1:0] down);
      longint          d [4];
      longint          total;
      longint          dev;
      longint unsigned acc;
      longint unsigned root;
      d[0] = wrapped_diff(center, up);
      d[1] = wrapped_diff(center, left);
      d[2] = wrapped_diff(center, right);
      d[3] = wrapped_diff(center, down);
      total = d[0] + d[1] + d[2] + d[3];
      acc = 0;
      // Deviations are scaled by four so the mean stays an integer.
      for (int k = 0; k < 4; k++) begin
         dev = 4 * d[k] - total;
         acc += dev * dev;
      end
      root = int_root(acc / 64);
      return root[QUALITY_BITS-1:0];
   endfunction

   // Frame size as the block uses it, after clamping.
   function automatic int unsigned used_width();
      int unsigned w;
      w = width_reg;
      if (w < 3)
         w = 3;
      if (w > LINE_DEPTH)
         w = LINE_DEPTH;
      return w;
   endfunction

   function automatic int unsigned used_height();
      return (height_reg < 3) ? 3 : height_reg;
   endfunction

   // Advances the predictor by one accepted pixel and queues its results.
   function automatic void derive_quality(input logic [PHASE_W-1:0] ph);
      int unsigned             w;
      int unsigned             h;
      int unsigned             c;
      int unsigned             r;
      bit                      last_col;
      bit                      last_row;
      logic [QUALITY_BITS-1:0] q;
      w = used_width();
      h = used_height();
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = row_pos;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      // The pixel directly above is released; border pixels give zero.
      if (r >= 1) begin
         q = '0;
         if (r >= 2 && c >= 1 && !last_col)
            q = gradient_spread(middle_line[c], upper_line[c], upper_line[c-1],
                                middle_line[c+1], ph);
         quality_queue.push_back('{q, ~last_row, 1'b0});
      end
      upper_line[c] = middle_line[c];
      middle_line[c] = ph;
      // A last-row pixel also closes its own position with a zero.
      if (last_row)
         quality_queue.push_back('{'0, 1'b1, last_col});
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   // Compares each result transfer with the oldest expectation.
   always @(posedge clock) begin : check_results
      quality_result_type want;
      quality_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_quality, rsp_last_in_run, rsp_end_of_frame};
         if (quality_queue.size() == 0) begin
            error_count++;
            $display("%0t ns: unexpected result, expected none, actual q=%0d l=%0b e=%0b",
                     $time, got.quality, got.last_in_run, got.end_of_frame);
         end else begin
            want = quality_queue.pop_front();
            result_count++;
            if (got !== want) begin
               error_count++;
               $display("%0t ns: result mismatch, expected q=%0d l=%0b e=%0b, actual q=%0d l=%0b e=%0b",
                        $time, want.quality, want.last_in_run, want.end_of_frame,
                        got.quality, got.last_in_run, got.end_of_frame);
            end
         end
      end
   end

   // Sends one pixel, with random idle cycles ahead of it.
   task automatic send_pixel(input logic [PHASE_W-1:0] ph);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_phase <= ph;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      derive_quality(ph);
      pixel_count++;
      @(negedge clock);
   endtask

   // Picks the next pixel value of a given texture.
   function automatic logic [PHASE_W-1:0] next_pixel(input pixel_kind_type kind);
      case (kind)
         PIX_UNIFORM: walk_phase = PHASE_W'($urandom_range(65535));
         PIX_SMOOTH: walk_phase = walk_phase + PHASE_W'($urandom_range(2047)) - 16'd1024;
         PIX_HALF: begin
            case ($urandom_range(7))
               0: walk_phase = 16'h0000;
               1: walk_phase = 16'h8000;
               2: walk_phase = 16'h7FFF;
               3: walk_phase = 16'h8001;
               4: walk_phase = 16'hFFFF;
               5: walk_phase = 16'h4000;
               6: walk_phase = 16'hC000;
               default: walk_phase = walk_phase ^ 16'h8000;
            endcase
         end
         default: ;
      endcase
      return walk_phase;
   endfunction

   task automatic send_pixels(input int count, input pixel_kind_type kind);
      for (int i = 0; i < count; i++)
         send_pixel(next_pixel(kind));
   endtask

   // Register write: setup cycle, then access cycle.
   task automatic csr_write(input logic [0:0] index, input logic [PDATA_BITS-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      // Any write restarts the frame; the line stores keep their contents.
      if (index == REG_IMAGE_WIDTH)
         width_reg = value[WIDTH_BITS-1:0];
      else
         height_reg = value[HEIGHT_BITS-1:0];
      col_pos = 0;
      row_pos = 0;
      write_count++;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // Register read, checked against the raw register copy.
   task automatic csr_read(input logic [0:0] index);
      logic [PDATA_BITS-1:0] want;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {index, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      want = (index == REG_IMAGE_WIDTH) ? PDATA_BITS'(width_reg) : PDATA_BITS'(height_reg);
      if (prdata !== want) begin
         error_count++;
         $display("%0t ns: register %0d read mismatch, expected %0d, actual %0d",
                  $time, index, want, prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every queued result has come, then lets the pipeline empty.
   task automatic wait_for_results(input int tail);
      int saved_stall;
      int waited;
      req_valid <= 1'b0;
      saved_stall = stall_pct;
      waited = 0;
      while (quality_queue.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      // Pixels that give no result may still be in flight, so stop stalling.
      stall_pct = 0;
      repeat (tail) @(negedge clock);
      stall_pct = saved_stall;
      if (quality_queue.size() != 0) begin
         error_count++;
         $display("%0t ns: %0d results never arrived, expected %0d more, actual 0",
                  $time, quality_queue.size(), quality_queue.size());
         quality_queue.delete();
      end
   endtask

   task automatic configure(input logic [PDATA_BITS-1:0] w, input logic [PDATA_BITS-1:0] h);
      wait_for_results(PIPE_TAIL);
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, h);
   endtask

   // Register values straight out of reset.
   task automatic test_reset_registers();
      csr_read(REG_IMAGE_WIDTH);
      csr_read(REG_IMAGE_HEIGHT);
   endtask

   // Part of the first row at the reset width of 640; no result is due yet.
   task automatic test_reset_size_rows();
      send_pixels(24, PIX_UNIFORM);
   endtask

   // Hand-picked frames: full-scale values, exact half cycles and wrap-around.
   task automatic test_directed_frames();
      logic [PHASE_W-1:0] grid3 [9];
      logic [PHASE_W-1:0] grid4 [16];
      grid3 = '{16'h0000, 16'hFFFF, 16'h8000,
                16'h8000, 16'h0000, 16'h7FFF,
                16'h0001, 16'h8000, 16'hFFFF};
      grid4 = '{16'h0000, 16'h0000, 16'hFFFF, 16'h5555,
                16'h0000, 16'h8000, 16'h0000, 16'hAAAA,
                16'hFFFF, 16'h8000, 16'h8001, 16'h0000,
                16'h7FFF, 16'h0000, 16'hFFFF, 16'h8000};
      configure(3, 3);
      foreach (grid3[i])
         send_pixel(grid3[i]);
      configure(4, 4);
      foreach (grid4[i])
         send_pixel(grid4[i]);
   endtask

   // Widest and tallest frames, out-of-range values and masked write data.
   task automatic test_register_extremes();
      // Width above the store size and height below three both clamp; the
      // first results show up only once a full 1024-pixel row is in.
      configure(2047, 1);
      csr_read(REG_IMAGE_WIDTH);
      csr_read(REG_IMAGE_HEIGHT);
      send_pixels(used_width() + 4, PIX_SMOOTH);
      // Narrowest and tallest frame, first rows only.
      configure(3, 4095);
      csr_read(REG_IMAGE_HEIGHT);
      send_pixels(used_width() * 6, PIX_UNIFORM);
      // Zero sizes clamp to 3 by 3; two frames back to back.
      configure(0, 0);
      send_pixels(18, PIX_HALF);
      // Bits above each register's width are dropped.
      configure(32'hFFFF_F805, 32'hFFFF_F004);
      csr_read(REG_IMAGE_WIDTH);
      csr_read(REG_IMAGE_HEIGHT);
      send_pixels(used_width() * used_height(), PIX_UNIFORM);
   endtask

   // Random register value: mostly in range, sometimes below the clamp.
   function automatic logic [PDATA_BITS-1:0] random_extent(input int top);
      if ($urandom_range(9) == 0)
         return PDATA_BITS'($urandom_range(2));
      return PDATA_BITS'($urandom_range(top, 3));
   endfunction

   // Small random frames, some cut short, under one idling pattern.
   task automatic run_random_phase(input int send_pct, input int stall, input int items);
      int             sent;
      int             count;
      int unsigned    pick;
      pixel_kind_type kind;
      bit             fresh;
      send_idle_pct = send_pct;
      stall_pct = stall;
      sent = 0;
      fresh = 1'b1;
      while (sent < items) begin
         if (fresh || $urandom_range(3) == 0) begin
            wait_for_results(PIPE_TAIL);
            pick = $urandom_range(2);
            if (pick != 2)
               csr_write(REG_IMAGE_WIDTH, random_extent(12));
            if (pick != 1)
               csr_write(REG_IMAGE_HEIGHT, random_extent(7));
            fresh = 1'b0;
         end
         kind = pixel_kind_type'($urandom_range(3));
         count = used_width() * used_height();
         if ($urandom_range(5) == 0)
            count = $urandom_range(count - 1, 1);
         send_pixels(count, kind);
         sent += count;
      end
      wait_for_results(PIPE_TAIL);
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, RANDOM_ITEMS);
      run_random_phase(54, 0, RANDOM_ITEMS);
      run_random_phase(0, 54, RANDOM_ITEMS);
      run_random_phase(31, 31, RANDOM_ITEMS);
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   // Test sequence.
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_registers();
      test_reset_size_rows();
      test_directed_frames();
      test_register_extremes();
      test_random_traffic();
      wait_for_results(PIPE_TAIL);
      $display("Covered %0d pixels and %0d results across %0d register writes,",
               pixel_count, result_count, write_count);
      $display("frame sizes from 3x3 up to 1024 wide and 4095 tall, with idle and stall phases.");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout after %0d ns", TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== phase_derivative_variance_map.f =====
hdl/pdvm_pkg.sv
hdl/pdvm_window.sv
hdl/pdvm_spread.sv
hdl/pdvm_sqrt_cell.sv
hdl/phase_derivative_variance_map.sv
bench/tb_phase_derivative_variance_map.sv
